// ===== hw/rtl/hit_pkg.sv =====
// ----------------------------------------------------------------------------
// hit_pkg: shared types and constants of the homography inlier test unit
// Payload structs, register indexes and the datapath widths of all stages.
// ----------------------------------------------------------------------------
package hit_pkg;

	localparam int COORD_W  = 16;
	localparam int COEF_W   = 32;
	localparam int PAIR_W   = 64;
	localparam int CFG_IDX_W = 8;
	localparam int PROD_W   = 49;  // 32 bit signed times 17 bit signed
	localparam int SUM_W    = 51;  // three product terms
	localparam int DEN_W    = 49;  // positive w
	localparam int NUM_W    = 60;  // rounded numerator magnitude
	localparam int Q_W      = 18;  // quotient bits kept before saturation
	localparam int CMP_W    = DEN_W + Q_W;
	localparam int DIV_LAT  = Q_W + 1;
	localparam int DIST_W   = 32;

	localparam logic [COEF_W-1:0] RST_COEF_ONE = 32'd16777216;
	localparam logic [COORD_W-1:0] RST_TOL     = 16'd48;
	localparam logic [DIST_W-1:0] DIST_MAX     = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_XX    = 8'd0,
		REG_COEF_XY    = 8'd1,
		REG_COEF_XT    = 8'd2,
		REG_COEF_YX    = 8'd3,
		REG_COEF_YY    = 8'd4,
		REG_COEF_YT    = 8'd5,
		REG_PERSP_PAIR = 8'd6,
		REG_TOLERANCE  = 8'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] src_x;
		logic [COORD_W-1:0] src_y;
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic              inlier;
		logic              degenerate;
		logic [DIST_W-1:0] dist_sq;
		logic              last_out;
	} result_t;

	// Per-item data that rides alongside the dividers.
	typedef struct packed {
		logic [COORD_W-1:0] dst_x;
		logic [COORD_W-1:0] dst_y;
		logic               last;
		logic               degen;
		logic               neg_x;
		logic               neg_y;
	} side_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] xx;
		logic signed [COEF_W-1:0] xy;
		logic signed [COEF_W-1:0] xt;
		logic signed [COEF_W-1:0] yx;
		logic signed [COEF_W-1:0] yy;
		logic signed [COEF_W-1:0] yt;
		logic signed [COEF_W-1:0] gx;
		logic signed [COEF_W-1:0] hy;
	} coef_t;

endpackage

// ===== hw/rtl/homography_inlier_test_unit.sv =====
// ----------------------------------------------------------------------------
// homography_inlier_test_unit: homography transfer error inlier test
// Maps a source point through the configured homography and tests its match.
// ----------------------------------------------------------------------------
// Usage:
// Point correspondences arrive on the point channel (valid/ready) and one
// result per point leaves on the result channel, in order. A transfer on the
// point channel is possible in every cycle unless a waiting result stalls the
// pipe, so the sustained rate is one item per clock without back-pressure. A
// point passes through three stages of projection, 19 stages of the two
// parallel bit-serial dividers (one range check plus one quotient bit per stage),
// and three stages of distance arithmetic ending in the output register.
// The homography and tolerance are written through cfg_we, cfg_index and
// cfg_data while no item is in flight; writes to an unknown index are dropped.
// Reset clears all valid bits and loads the identity homography with a
// tolerance of 48 coordinate units.
// When the receiver holds result_ready low with a result waiting, the whole
// pipeline holds in place and point_ready drops; bubbles ahead of a waiting
// result stall with the rest of the pipe, and no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module homography_inlier_test_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  hit_pkg::point_t               point,
	output logic                          result_valid,
	input  logic                          result_ready,
	output hit_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [hit_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hit_pkg::PAIR_W-1:0]    cfg_data
);
	import hit_pkg::*;

	// Configuration registers.
	logic [COEF_W-1:0]  coef_xx_q, coef_xy_q, coef_xt_q;
	logic [COEF_W-1:0]  coef_yx_q, coef_yy_q, coef_yt_q;
	logic [PAIR_W-1:0]  persp_pair_q;
	logic [COORD_W-1:0] tolerance_q;
	coef_t              coef;

	// Pipeline control: everything advances together unless a result waits.
	logic               en;
	logic               valid_p3;
	logic [NUM_W-1:0]   num_x_p3, num_y_p3;
	logic [DEN_W-1:0]   den_p3;
	side_t              side_p3;
	logic [Q_W-1:0]     quo_x, quo_y;
	logic               ovf_x, ovf_y;
	logic               vld_s [0:DIV_LAT-1];
	side_t              side_s [0:DIV_LAT-1];

	assign en          = !result_valid || result_ready;
	assign point_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q    <= RST_COEF_ONE;
			coef_xy_q    <= '0;
			coef_xt_q    <= '0;
			coef_yx_q    <= '0;
			coef_yy_q    <= RST_COEF_ONE;
			coef_yt_q    <= '0;
			persp_pair_q <= '0;
			tolerance_q  <= RST_TOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_XX:    coef_xx_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_XY:    coef_xy_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_XT:    coef_xt_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_YX:    coef_yx_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_YY:    coef_yy_q    <= cfg_data[COEF_W-1:0];
				REG_COEF_YT:    coef_yt_q    <= cfg_data[COEF_W-1:0];
				REG_PERSP_PAIR: persp_pair_q <= cfg_data;
				REG_TOLERANCE:  tolerance_q  <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign coef.xx = coef_xx_q;
	assign coef.xy = coef_xy_q;
	assign coef.xt = coef_xt_q;
	assign coef.yx = coef_yx_q;
	assign coef.yy = coef_yy_q;
	assign coef.yt = coef_yt_q;
	assign coef.gx = persp_pair_q[COEF_W-1:0];
	assign coef.hy = persp_pair_q[PAIR_W-1:COEF_W];

	hit_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (point_valid),
		.point    (point),
		.coef     (coef),
		.valid_s3 (valid_p3),
		.num_x_s3 (num_x_p3),
		.num_y_s3 (num_y_p3),
		.den_s3   (den_p3),
		.side_s3  (side_p3)
	);

	hit_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (num_x_p3),
		.den (den_p3),
		.quo (quo_x),
		.ovf (ovf_x)
	);

	hit_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (num_y_p3),
		.den (den_p3),
		.quo (quo_y),
		.ovf (ovf_y)
	);

	// Valid bits and side data follow the divider stages one for one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= valid_p3;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_p3;
			for (int i = 1; i < DIV_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	hit_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (vld_s[DIV_LAT-1]),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.ovf_x     (ovf_x),
		.ovf_y     (ovf_y),
		.side      (side_s[DIV_LAT-1]),
		.tolerance (tolerance_q),
		.valid_s3  (result_valid),
		.result_s3 (result)
	);

endmodule

// ===== hw/rtl/hit_proj.sv =====
// ----------------------------------------------------------------------------
// hit_proj: projective mapping front end
// Three stages: products, sums for u, v and w, then numerator and divisor.
// ----------------------------------------------------------------------------
module hit_proj (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid,
	input  hit_pkg::point_t             point,
	input  hit_pkg::coef_t              coef,
	output logic                        valid_s3,
	output logic [hit_pkg::NUM_W-1:0]   num_x_s3,
	output logic [hit_pkg::NUM_W-1:0]   num_y_s3,
	output logic [hit_pkg::DEN_W-1:0]   den_s3,
	output hit_pkg::side_t              side_s3
);
	import hit_pkg::*;

	logic signed [PROD_W-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_gx_s1, p_hy_s1;
	point_t                   point_s1;
	logic                     valid_s1, valid_s2;
	logic signed [SUM_W-1:0]  u_s2, v_s2, w_s2;
	point_t                   point_s2;

	logic signed [COORD_W:0]  sx, sy;
	logic signed [SUM_W-1:0]  u_c, v_c, w_c;
	logic [SUM_W-1:0]         abs_u, abs_v;
	logic                     degen_c;
	logic [DEN_W-1:0]         den_c;

	assign sx = $signed({1'b0, point.src_x});
	assign sy = $signed({1'b0, point.src_y});

	assign u_c = SUM_W'(p_xx_s1) + SUM_W'(p_xy_s1) + (SUM_W'(coef.xt) <<< 12);
	assign v_c = SUM_W'(p_yx_s1) + SUM_W'(p_yy_s1) + (SUM_W'(coef.yt) <<< 12);
	assign w_c = SUM_W'(p_gx_s1) + SUM_W'(p_hy_s1) + (SUM_W'(1) <<< 34);

	assign abs_u   = u_s2[SUM_W-1] ? SUM_W'(-u_s2) : SUM_W'(u_s2);
	assign abs_v   = v_s2[SUM_W-1] ? SUM_W'(-v_s2) : SUM_W'(v_s2);
	assign degen_c = w_s2[SUM_W-1] || (w_s2 == '0);
	assign den_c   = w_s2[DEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_xx_s1  <= coef.xx * sx;
			p_xy_s1  <= coef.xy * sy;
			p_yx_s1  <= coef.yx * sx;
			p_yy_s1  <= coef.yy * sy;
			p_gx_s1  <= coef.gx * sx;
			p_hy_s1  <= coef.hy * sy;
			point_s1 <= point;

			u_s2     <= u_c;
			v_s2     <= v_c;
			w_s2     <= w_c;
			point_s2 <= point_s1;

			// Adding half the divisor makes the quotient round half away from zero.
			num_x_s3 <= {1'b0, abs_u[DEN_W-1:0], 10'b0} + {12'b0, den_c[DEN_W-1:1]};
			num_y_s3 <= {1'b0, abs_v[DEN_W-1:0], 10'b0} + {12'b0, den_c[DEN_W-1:1]};
			den_s3   <= den_c;
			side_s3.dst_x <= point_s2.dst_x;
			side_s3.dst_y <= point_s2.dst_y;
			side_s3.last  <= point_s2.last_point;
			side_s3.degen <= degen_c;
			side_s3.neg_x <= u_s2[SUM_W-1];
			side_s3.neg_y <= v_s2[SUM_W-1];
		end
	end

endmodule

// ===== hw/rtl/hit_div.sv =====
// ----------------------------------------------------------------------------
// hit_div: pipelined restoring divider
// One range check stage, then one quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module hit_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hit_pkg::NUM_W-1:0]  num,
	input  logic [hit_pkg::DEN_W-1:0]  den,
	output logic [hit_pkg::Q_W-1:0]    quo,
	output logic                       ovf
);
	import hit_pkg::*;

	logic [NUM_W-1:0] rem_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic [Q_W-1:0]   quo_s [0:Q_W];
	logic             ovf_s [0:Q_W];

	// A quotient that needs more than Q_W bits is flagged and saturates later.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= {{(CMP_W-NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		localparam int K = Q_W - 1 - i;
		logic [CMP_W-1:0] shifted;
		logic             take;

		assign shifted = {{Q_W{1'b0}}, den_s[i]} << K;
		assign take    = {{(CMP_W-NUM_W){1'b0}}, rem_s[i]} >= shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? NUM_W'({{(CMP_W-NUM_W){1'b0}}, rem_s[i]} - shifted)
				                   : rem_s[i];
				quo_s[i+1] <= quo_s[i] | (take ? (Q_W'(1) << K) : '0);
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quo = quo_s[Q_W];
	assign ovf = ovf_s[Q_W];

endmodule

// ===== hw/rtl/hit_dist.sv =====
// ----------------------------------------------------------------------------
// hit_dist: distance and inlier decision back end
// Differences, squares, then the saturated sum and the tolerance compare.
// ----------------------------------------------------------------------------
module hit_dist (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid,
	input  logic [hit_pkg::Q_W-1:0]     quo_x,
	input  logic [hit_pkg::Q_W-1:0]     quo_y,
	input  logic                        ovf_x,
	input  logic                        ovf_y,
	input  hit_pkg::side_t              side,
	input  logic [hit_pkg::COORD_W-1:0] tolerance,
	output logic                        valid_s3,
	output hit_pkg::result_t            result_s3
);
	import hit_pkg::*;

	localparam int D_W = Q_W + 2;

	logic signed [D_W-1:0]  px, py, dx, dy;
	logic [D_W-1:0]         adx, ady;
	logic                   valid_s1, valid_s2;
	logic [COORD_W-1:0]     adx_s1, ady_s1;
	logic                   sat_s1, sat_s2, degen_s1, degen_s2, last_s1, last_s2;
	logic [DIST_W-1:0]      sq_x_s2, sq_y_s2, tol_sq_s2;
	logic [DIST_W:0]        sum;
	logic [DIST_W-1:0]      dist_val;
	logic                   sat_any;

	assign px  = side.neg_x ? -$signed({2'b0, quo_x}) : $signed({2'b0, quo_x});
	assign py  = side.neg_y ? -$signed({2'b0, quo_y}) : $signed({2'b0, quo_y});
	assign dx  = px - $signed({{(D_W-COORD_W){1'b0}}, side.dst_x});
	assign dy  = py - $signed({{(D_W-COORD_W){1'b0}}, side.dst_y});
	assign adx = dx[D_W-1] ? D_W'(-dx) : D_W'(dx);
	assign ady = dy[D_W-1] ? D_W'(-dy) : D_W'(dy);

	assign sum      = {1'b0, sq_x_s2} + {1'b0, sq_y_s2};
	assign sat_any  = sat_s2 || degen_s2 || sum[DIST_W];
	assign dist_val = sat_any ? DIST_MAX : sum[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1   <= adx[COORD_W-1:0];
			ady_s1   <= ady[COORD_W-1:0];
			sat_s1   <= ovf_x || ovf_y || (adx[D_W-1:COORD_W] != '0)
			            || (ady[D_W-1:COORD_W] != '0);
			degen_s1 <= side.degen;
			last_s1  <= side.last;

			sq_x_s2   <= adx_s1 * adx_s1;
			sq_y_s2   <= ady_s1 * ady_s1;
			tol_sq_s2 <= tolerance * tolerance;
			sat_s2    <= sat_s1;
			degen_s2  <= degen_s1;
			last_s2   <= last_s1;

			result_s3.dist_sq    <= dist_val;
			result_s3.inlier     <= !sat_any && (dist_val <= tol_sq_s2);
			result_s3.degenerate <= degen_s2;
			result_s3.last_out   <= last_s2;
		end
	end

endmodule
